### design/row_four_byte_contains_filter_macros.svh
// ---------------------------------------------------------------------------
// row_four_byte_contains_filter_macros.svh
// Assertion helpers shared by the filter's checkers.
// ---------------------------------------------------------------------------
`ifndef ROW_FOUR_BYTE_CONTAINS_FILTER_MACROS_SVH
`define ROW_FOUR_BYTE_CONTAINS_FILTER_MACROS_SVH

// Concurrent assertion, muted while reset is asserted.
`define RFBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also checks through reset.
`define RFBC_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rfbc_pkg.sv
// ---------------------------------------------------------------------------
// rfbc_pkg
// Widths, constants and shared types of the row contains filter.
// ---------------------------------------------------------------------------
`default_nettype none

package rfbc_pkg;

    localparam int BYTE_W = 8;
    localparam int ROW_W  = 16;
    localparam int SLOT_W = 16;
    localparam int CODE_W = 32;

    localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

    // one input item as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              last_in_row;
        logic              row_valid;
        logic [ROW_W-1:0]  row_index;
        logic              batch_start;
    } t_in_item;

    // per-item control from the top level to the window matcher
    typedef struct packed {
        logic step;      // item leaves the input register this cycle
        logic present;   // item carries a real byte
        logic last;      // item closes the row
    } t_step;

endpackage

`default_nettype wire

### design/rfbc_in_if.sv
// ---------------------------------------------------------------------------
// rfbc_in_if
// Byte stream channel: one row byte with its row tags per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface rfbc_in_if;
    import rfbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              last_in_row;
    logic              row_valid;
    logic [ROW_W-1:0]  row_index;
    logic              batch_start;

    modport source (
        output valid, data_byte, byte_present, last_in_row, row_valid,
               row_index, batch_start,
        input  ready
    );

    modport sink (
        input  valid, data_byte, byte_present, last_in_row, row_valid,
               row_index, batch_start,
        output ready
    );
endinterface

`default_nettype wire

### design/rfbc_out_if.sv
// ---------------------------------------------------------------------------
// rfbc_out_if
// Result channel: row number and compacted slot of a matching row.
// ---------------------------------------------------------------------------
`default_nettype none

interface rfbc_out_if;
    import rfbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  kept_row;
    logic [SLOT_W-1:0] out_slot;

    modport source (
        output valid, kept_row, out_slot,
        input  ready
    );

    modport sink (
        input  valid, kept_row, out_slot,
        output ready
    );
endinterface

`default_nettype wire

### design/rfbc_matcher.sv
// ---------------------------------------------------------------------------
// rfbc_matcher
// Sliding byte window of the current row, compared against the code, with
// a sticky per-row hit flag.
// ---------------------------------------------------------------------------
`default_nettype none

module rfbc_matcher #(
    parameter int CODE_BYTES = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire rfbc_pkg::t_step         i_ctl,
    input  wire [rfbc_pkg::BYTE_W-1:0]   i_byte,
    input  wire [rfbc_pkg::CODE_W-1:0]   i_code,
    output logic                         o_hit
);
    import rfbc_pkg::*;

    localparam int CMP_W     = CODE_BYTES * BYTE_W;
    localparam int WIN_BYTES = CODE_BYTES - 1;
    localparam int SEEN_W    = (CODE_BYTES > 2) ? $clog2(CODE_BYTES) : 1;

    logic [CMP_W-1:0] code_ext;
    logic             hit_now;
    logic             r_match;
    logic             n_match;

    // pattern bytes beyond the register are zero
    generate
        if (CMP_W <= CODE_W) begin : g_code_cut
            assign code_ext = i_code[CMP_W-1:0];
        end else begin : g_code_ext
            assign code_ext = {{(CMP_W-CODE_W){1'b0}}, i_code};
        end
    endgenerate

    generate
        if (CODE_BYTES == 1) begin : g_single
            assign hit_now = i_ctl.present && (i_byte == code_ext);
        end else begin : g_window
            logic [BYTE_W-1:0] r_win [WIN_BYTES];
            logic [BYTE_W-1:0] n_win [WIN_BYTES];
            logic [SEEN_W-1:0] r_seen;
            logic [SEEN_W-1:0] n_seen;
            logic [CMP_W-1:0]  cand;
            logic              full;

            assign full = (r_seen == SEEN_W'(WIN_BYTES));

            always_comb begin
                for (int k = 0; k < WIN_BYTES; k++) begin
                    cand[k*BYTE_W +: BYTE_W] = r_win[k];
                end
                cand[WIN_BYTES*BYTE_W +: BYTE_W] = i_byte;
            end

            assign hit_now = i_ctl.present && full && (cand == code_ext);

            always_comb begin
                n_seen = r_seen;
                for (int k = 0; k < WIN_BYTES; k++) begin
                    n_win[k] = r_win[k];
                end
                if (i_ctl.step) begin
                    if (i_ctl.last) begin
                        n_seen = '0;
                    end else if (i_ctl.present) begin
                        if (full) begin
                            // oldest byte drops out at slot 0
                            for (int k = 0; k < WIN_BYTES; k++) begin
                                n_win[k] = cand[(k+1)*BYTE_W +: BYTE_W];
                            end
                        end else begin
                            for (int k = 0; k < WIN_BYTES; k++) begin
                                if (r_seen == SEEN_W'(k)) begin
                                    n_win[k] = i_byte;
                                end
                            end
                            n_seen = r_seen + SEEN_W'(1);
                        end
                    end
                end
            end

            // window slots are only read once all are written in this row
            always_ff @(posedge i_clk) begin
                for (int k = 0; k < WIN_BYTES; k++) begin
                    r_win[k] <= n_win[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_seen <= '0;
                end else begin
                    r_seen <= n_seen;
                end
            end
        end
    endgenerate

    assign o_hit = r_match || hit_now;

    always_comb begin
        n_match = r_match;
        if (i_ctl.step) begin
            n_match = i_ctl.last ? 1'b0 : o_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

endmodule

`default_nettype wire

### design/row_four_byte_contains_filter.sv
// ---------------------------------------------------------------------------
// row_four_byte_contains_filter
// Keeps rows of a string column that contain a configured byte code.
// ---------------------------------------------------------------------------
// Takes one row byte per cycle while input ready is high. An item passes an
// input register, the window compare and the slot counter. A matching row
// moves from the input register into a result register and then shows on
// the result channel. Only an item that closes a matching row can wait in
// the input register, and only while the previous result is still unaccepted;
// input ready then follows the result ready. Rows that do not match, and
// items that are not last in their row, produce nothing. The code register
// may be written only while the block holds no item.
`default_nettype none

module row_four_byte_contains_filter #(
    parameter int CODE_BYTES = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    rfbc_in_if.sink                      i_in,
    rfbc_out_if.source                   o_out,
    input  wire                          i_cfg_we,
    input  wire [rfbc_pkg::CODE_W-1:0]   i_cfg_data
);
    import rfbc_pkg::*;

    logic [CODE_W-1:0] r_code;
    logic              r_s1_valid;
    t_in_item          r_s1;
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_kept_row;
    logic [SLOT_W-1:0] r_out_slot;
    logic [SLOT_W-1:0] r_slot_count;
    logic [SLOT_W-1:0] n_slot_count;
    logic [SLOT_W-1:0] slot_cur;
    logic              out_free;
    logic              hit;
    logic              will_emit;
    logic              s1_take;
    logic              emit;
    t_step             ctl;

    assign out_free  = !r_out_valid || o_out.ready;
    assign will_emit = r_s1.last_in_row && r_s1.row_valid && hit;
    // a non-matching item never needs the result register
    assign s1_take   = r_s1_valid && (out_free || !will_emit);
    assign emit      = s1_take && will_emit;
    assign i_in.ready = !r_s1_valid || s1_take;

    assign ctl.step    = s1_take;
    assign ctl.present = r_s1.byte_present;
    assign ctl.last    = r_s1.last_in_row;

    rfbc_matcher #(
        .CODE_BYTES (CODE_BYTES)
    ) u_matcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (r_s1.data_byte),
        .i_code  (r_code),
        .o_hit   (hit)
    );

    assign slot_cur = r_s1.batch_start ? '0 : r_slot_count;

    always_comb begin
        n_slot_count = r_slot_count;
        if (s1_take) begin
            n_slot_count = slot_cur;
            if (emit && (slot_cur != SLOT_MAX)) begin
                n_slot_count = slot_cur + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code       <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_code <= i_cfg_data;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_slot_count <= n_slot_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.data_byte    <= i_in.data_byte;
            r_s1.byte_present <= i_in.byte_present;
            r_s1.last_in_row  <= i_in.last_in_row;
            r_s1.row_valid    <= i_in.row_valid;
            r_s1.row_index    <= i_in.row_index;
            r_s1.batch_start  <= i_in.batch_start;
        end
        if (emit) begin
            r_kept_row <= r_s1.row_index;
            r_out_slot <= slot_cur;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kept_row = r_kept_row;
    assign o_out.out_slot = r_out_slot;

endmodule

`default_nettype wire

### design/rfbc_checker.sv
// ---------------------------------------------------------------------------
// rfbc_checker
// Port-level checks of the row contains filter, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "row_four_byte_contains_filter_macros.svh"

module rfbc_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire [rfbc_pkg::ROW_W-1:0]    i_kept_row,
    input  wire [rfbc_pkg::SLOT_W-1:0]   i_out_slot
);
    import rfbc_pkg::*;

    logic              r_prev_valid;
    logic              r_prev_take;
    logic              r_have_slot;
    logic [SLOT_W-1:0] r_last_slot;
    logic              new_item;
    logic              slot_ok;

    // a result item seen for the first time on the port
    assign new_item = i_out_valid && (!r_prev_valid || r_prev_take);

    // slots step by one, stick at the top, or restart with a new batch
    assign slot_ok = !r_have_slot
                  || (i_out_slot == '0)
                  || (i_out_slot == r_last_slot + SLOT_W'(1))
                  || ((r_last_slot == SLOT_MAX) && (i_out_slot == SLOT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_take  <= 1'b0;
            r_have_slot  <= 1'b0;
        end else begin
            r_prev_valid <= i_out_valid;
            r_prev_take  <= i_out_valid && i_out_ready;
            if (i_out_valid && i_out_ready) begin
                r_have_slot <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_valid && i_out_ready) begin
            r_last_slot <= i_out_slot;
        end
    end

    `RFBC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kept_row) && $stable(i_out_slot), "result changed while stalled")
    `RFBC_ASSERT_ANY(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid right after reset")
    `RFBC_ASSERT(a_slot_seq, i_clk, i_rst_n, new_item |-> slot_ok, "output slot out of sequence")

endmodule

bind row_four_byte_contains_filter rfbc_checker u_rfbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kept_row  (o_out.kept_row),
    .i_out_slot  (o_out.out_slot)
);

`default_nettype wire

### bench/rfbc_filter_checker.sv
// ---------------------------------------------------------------------------
// rfbc_filter_checker
// Watches the byte stream and the result channel of the contains filter,
// runs its own window matcher and slot counter on every accepted item and
// compares each accepted result, field by field, with the oldest kept row.
// ---------------------------------------------------------------------------
module rfbc_filter_checker
    import rfbc_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    rfbc_in_if               i_in,
    rfbc_out_if              i_out,
    input  wire              i_cfg_we,
    input  wire [CODE_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_BYTES = 4;
    localparam int WIN_W      = (CODE_BYTES - 1) * BYTE_W;

    typedef struct packed {
        logic [ROW_W-1:0]  kept_row;
        logic [SLOT_W-1:0] out_slot;
    } t_kept;

    t_kept             kept_q[$];
    logic [CODE_W-1:0] code_r;
    logic [WIN_W-1:0]  window_r;
    int                fill_r;
    logic              hit_r;
    logic [SLOT_W-1:0] slot_r;
    int                fail_n = 0;

    assign o_fail_count = fail_n;

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        fail_n++;
        if (fail_n <= 40)
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
    endtask

    function automatic void clear_row();
        window_r = '0;
        fill_r   = 0;
        hit_r    = 1'b0;
    endfunction

    function automatic void match_item(input t_in_item it);
        logic [CODE_W-1:0] cand;
        if (it.batch_start)
            slot_r = '0;
        if (it.byte_present) begin
            if (fill_r == CODE_BYTES - 1) begin
                cand = {it.data_byte, window_r};
                if (cand == code_r)
                    hit_r = 1'b1;
                window_r = cand[CODE_W-1:BYTE_W];
            end else begin
                window_r[fill_r*BYTE_W +: BYTE_W] = it.data_byte;
                fill_r++;
            end
        end
        if (it.last_in_row) begin
            if (it.row_valid && hit_r) begin
                kept_q.push_back('{kept_row: it.row_index, out_slot: slot_r});
                if (slot_r != SLOT_MAX)
                    slot_r++;
            end
            clear_row();
        end
    endfunction

    always @(posedge i_clk) begin
        t_kept want;
        if (!i_rst_n) begin
            kept_q.delete();
            code_r = '0;
            slot_r = '0;
            clear_row();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (kept_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 40)
                        $display("%0t ns: unexpected result, expected none actual row %h slot %h",
                                 $time, i_out.kept_row, i_out.out_slot);
                end else begin
                    want = kept_q.pop_front();
                    if (i_out.kept_row !== want.kept_row)
                        report("kept_row", want.kept_row, i_out.kept_row);
                    if (i_out.out_slot !== want.out_slot)
                        report("out_slot", want.out_slot, i_out.out_slot);
                end
            end
            if (i_cfg_we)
                code_r = i_cfg_data;
            if (i_in.valid && i_in.ready)
                match_item('{data_byte:    i_in.data_byte,
                             byte_present: i_in.byte_present,
                             last_in_row:  i_in.last_in_row,
                             row_valid:    i_in.row_valid,
                             row_index:    i_in.row_index,
                             batch_start:  i_in.batch_start});
        end
        o_pending = kept_q.size();
    end
endmodule

### bench/tb_row_four_byte_contains_filter.sv
// ---------------------------------------------------------------------------
// tb_row_four_byte_contains_filter
// Drives rows of bytes through the contains filter under several codes:
// directed rows first, then random rows with planted codes, noise bytes,
// random stalls on both channels and a long result hold-off. The checker
// judges every result.
// ---------------------------------------------------------------------------
module tb_row_four_byte_contains_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import rfbc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CODE_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                items_sent = 0;
    bit                hold_req = 1'b0;

    rfbc_in_if  in_ch ();
    rfbc_out_if out_ch ();

    row_four_byte_contains_filter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    rfbc_filter_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (hold_req)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random ready stretches, one long hold-off on request
    initial begin
        int  len;
        bit  ready_on;
        out_ch.ready = 1'b0;
        ready_on = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                if (ready_on)
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 20);
                else
                    len = pick_gap() + 1;
                out_ch.ready <= ready_on;
                repeat (len - 1) @(negedge clk);
                ready_on = !ready_on;
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input bit present, input bit last,
                             input bit row_ok, input logic [15:0] row, input bit batch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.byte_present <= present;
        in_ch.last_in_row  <= last;
        in_ch.row_valid    <= row_ok;
        in_ch.row_index    <= row;
        in_ch.batch_start  <= batch;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // idle the stream, let the block empty out, then load a new code
    task automatic load_code(input logic [CODE_W-1:0] code);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= code;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_row(input logic [CODE_W-1:0] pat);
        int          len;
        int          pos;
        int          r;
        bit          batch;
        bit          row_ok;
        bit          pad_end;
        logic [15:0] row;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = 0;
        else if (r < 90)
            len = $urandom_range(1, 10);
        else
            len = $urandom_range(11, 40);
        pos     = (len >= 4 && $urandom_range(0, 1) == 1) ? $urandom_range(0, len - 4) : -1;
        batch   = ($urandom_range(0, 99) < 8);
        row_ok  = ($urandom_range(0, 99) < 80);
        pad_end = (len > 0 && $urandom_range(0, 99) < 5);
        row     = 16'($urandom);
        if (len == 0)
            send_byte(8'($urandom), 1'b0, 1'b1, row_ok, row, batch);
        for (int k = 0; k < len; k++) begin
            if (pos >= 0 && k >= pos && k < pos + 4)
                b = pat[8*(k-pos) +: 8];
            else if ($urandom_range(0, 2) == 0)
                b = pat[8*$urandom_range(0, 3) +: 8];
            else
                b = 8'($urandom);
            // stray empty marker inside the row
            if ($urandom_range(0, 99) < 4)
                send_byte(8'($urandom), 1'b0, 1'b0, 1'($urandom), 16'($urandom), batch);
            if (k == len - 1 && !pad_end)
                send_byte(b, 1'b1, 1'b1, row_ok, row, batch);
            else
                send_byte(b, 1'b1, 1'b0, 1'($urandom),
                          ($urandom_range(0, 9) != 0) ? row : 16'($urandom),
                          batch || ($urandom_range(0, 49) == 0));
        end
        if (pad_end)
            send_byte(8'($urandom), 1'b0, 1'b1, row_ok, row, batch);
    endtask

    task automatic random_phase(input logic [CODE_W-1:0] pat, input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_random_row(pat);
    endtask

    initial begin
        logic [CODE_W-1:0] code;
        int                w;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.data_byte    = '0;
        in_ch.byte_present = 1'b0;
        in_ch.last_in_row  = 1'b0;
        in_ch.row_valid    = 1'b0;
        in_ch.row_index    = '0;
        in_ch.batch_start  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows, code bytes 11 22 33 44 in stream order
        load_code(32'h4433_2211);
        send_byte(8'h11, 1, 0, 1, 16'h0000, 1);
        send_byte(8'h22, 1, 0, 1, 16'h0000, 1);
        send_byte(8'h33, 1, 0, 1, 16'h0000, 1);
        send_byte(8'h44, 1, 1, 1, 16'h0000, 1);
        // too short to hit
        send_byte(8'h11, 1, 0, 1, 16'h0001, 0);
        send_byte(8'h22, 1, 0, 1, 16'h0001, 0);
        send_byte(8'h33, 1, 1, 1, 16'h0001, 0);
        // empty row
        send_byte(8'hFF, 0, 1, 1, 16'hFFFF, 0);
        // validity and row number come from the last item only
        send_byte(8'hFF, 1, 0, 0, 16'h1234, 0);
        send_byte(8'h11, 1, 0, 0, 16'h1234, 0);
        send_byte(8'h22, 1, 0, 0, 16'h1234, 0);
        send_byte(8'h33, 1, 0, 0, 16'h1234, 0);
        send_byte(8'h44, 1, 1, 1, 16'hFFFF, 0);
        // null row holding the code
        send_byte(8'h11, 1, 0, 1, 16'h0007, 0);
        send_byte(8'h22, 1, 0, 1, 16'h0007, 0);
        send_byte(8'h33, 1, 0, 1, 16'h0007, 0);
        send_byte(8'h44, 1, 1, 0, 16'h0007, 0);
        // markers inside the row and closing it, code still hits
        send_byte(8'h11, 1, 0, 1, 16'h8000, 0);
        send_byte(8'h22, 1, 0, 1, 16'h8000, 0);
        send_byte(8'hFF, 0, 0, 1, 16'h8000, 0);
        send_byte(8'h33, 1, 0, 1, 16'h8000, 0);
        send_byte(8'h44, 1, 0, 1, 16'h8000, 0);
        send_byte(8'h00, 0, 1, 1, 16'h8000, 0);
        // new batch restarts the slot
        send_byte(8'h00, 1, 0, 1, 16'h0005, 1);
        send_byte(8'h11, 1, 0, 1, 16'h0005, 1);
        send_byte(8'h22, 1, 0, 1, 16'h0005, 1);
        send_byte(8'h33, 1, 0, 1, 16'h0005, 1);
        send_byte(8'h44, 1, 1, 1, 16'h0005, 1);

        code = $urandom;
        load_code(code);
        random_phase(code, 300);

        // zero code, and the result side holds off while bytes keep coming
        load_code(32'h0000_0000);
        hold_req = 1'b1;
        random_phase(32'h0000_0000, 300);

        // all-ones code
        load_code(32'hFFFF_FFFF);
        random_phase(32'hFFFF_FFFF, 300);

        // repeated bytes give overlapping hits
        load_code(32'h4141_4141);
        random_phase(32'h4141_4141, 300);

        code = $urandom;
        load_code(code);
        random_phase(code, 250);

        in_ch.valid <= 1'b0;
        for (w = 0; w < 2000 && pending != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
